// ----- design/gchsc_pkg.sv -----
// ----------------------------------------------------------------------------
// gchsc_pkg: shared types and constants for the cell height classifier
// Point and layer statistic types, map limits and register indexes.
// ----------------------------------------------------------------------------
package gchsc_pkg;

  localparam int HEIGHT_BITS   = 24;
  localparam int MAX_CELL_COLS = 1024;
  localparam int ROW_LIMIT     = 1024;

  // line buffer holds one point row
  localparam int LB_DEPTH = MAX_CELL_COLS + 1;
  localparam int LB_AW    = $clog2(LB_DEPTH);

  // configuration port
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;
  localparam int DELTA_W     = 24;
  localparam int CFG_COUNT_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_SLOPE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_COLS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_ROWS   = 2'd2;

  localparam logic [DELTA_W-1:0]     DELTA_RESET = DELTA_W'(256);
  localparam logic [CFG_COUNT_W-1:0] COLS_RESET  = CFG_COUNT_W'(1024);
  localparam logic [CFG_COUNT_W-1:0] ROWS_RESET  = CFG_COUNT_W'(1024);

  // comparison width for column and row counts
  localparam int CMP_W = (LB_AW > CFG_COUNT_W) ? LB_AW : CFG_COUNT_W;
  localparam int ROW_W = $clog2(ROW_LIMIT + 1);
  localparam int COORD_W = 10;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 72;

  typedef logic signed [HEIGHT_BITS-1:0] height_t;

  typedef struct packed {
    logic    bridge_inf;
    height_t bridge_height;
    logic    terrain_inf;
    height_t terrain_height;
  } point_t;

  typedef struct packed {
    height_t mn;
    height_t mx;
    logic    inf;
  } layer_stat_t;

endpackage

// ----- design/grid_cell_height_slope_classifier_unit.sv -----
// ----------------------------------------------------------------------------
// grid_cell_height_slope_classifier_unit: two-layer cell height classifier
// Raster points in, one cell per 2x2 corner window out.
// ----------------------------------------------------------------------------
// Takes one point per clock cycle; a cell passes s1, s2 and out after the
// point that completes its window. The rate is set by the line buffer, which
// reads the north neighbour and writes the new point at the same address in
// the transfer cycle. A stalled output holds its cell while two further
// cell-making points still enter; points that make no cell keep flowing.
// cfg writes are taken at any time and are meant for an idle block.
module grid_cell_height_slope_classifier_unit import gchsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // terrain_height, terrain_inf, bridge_height, bridge_inf, zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // terrain_cell_height, terrain_cell_inf, terrain_blocked,
  // bridge_cell_height, bridge_cell_inf, bridge_blocked, cell_col, cell_row
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration
  logic [DELTA_W-1:0]     slope_limit_r;
  logic [CFG_COUNT_W-1:0] cell_cols_r;
  logic [CFG_COUNT_W-1:0] cell_rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slope_limit_r <= DELTA_RESET;
      cell_cols_r   <= COLS_RESET;
      cell_rows_r   <= ROWS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SLOPE_LIMIT: slope_limit_r <= cfg_data[DELTA_W-1:0];
        REG_CELL_COLS:   cell_cols_r   <= cfg_data[CFG_COUNT_W-1:0];
        REG_CELL_ROWS:   cell_rows_r   <= cfg_data[CFG_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective counts
  logic [LB_AW-1:0] cols_eff;
  logic [ROW_W-1:0] rows_eff;

  always_comb begin
    if (cell_cols_r == '0) begin
      cols_eff = LB_AW'(1);
    end else if (CMP_W'(cell_cols_r) > CMP_W'(MAX_CELL_COLS)) begin
      cols_eff = LB_AW'(MAX_CELL_COLS);
    end else begin
      cols_eff = LB_AW'(cell_cols_r);
    end
    if (cell_rows_r == '0) begin
      rows_eff = ROW_W'(1);
    end else if (CMP_W'(cell_rows_r) > CMP_W'(ROW_LIMIT)) begin
      rows_eff = ROW_W'(ROW_LIMIT);
    end else begin
      rows_eff = ROW_W'(cell_rows_r);
    end
  end

  // pipeline control
  logic s1_v_r, s1_v_nxt;
  logic s2_v_r, s2_v_nxt;
  logic out_v_r, out_v_nxt;
  logic s1_emit_r;
  logic out_free, s2_go, s2_free, s1_go, in_xfer;

  always_comb begin
    out_free  = !out_v_r || out_tready;
    s2_go     = s2_v_r && out_free;
    s2_free   = !s2_v_r || s2_go;
    s1_go     = s1_v_r && (!s1_emit_r || s2_free);
    in_tready = !s1_v_r || s1_go;
    in_xfer   = in_tvalid && in_tready;
    s1_v_nxt  = in_xfer ? 1'b1 : (s1_go ? 1'b0 : s1_v_r);
    s2_v_nxt  = (s1_go && s1_emit_r) ? 1'b1 : (s2_go ? 1'b0 : s2_v_r);
    out_v_nxt = s2_go ? 1'b1 : (out_tready ? 1'b0 : out_v_r);
  end

  // point position
  logic [LB_AW-1:0] point_col_r, point_col_nxt;
  logic [ROW_W-1:0] point_row_r, point_row_nxt;
  logic [LB_AW-1:0] col_c;
  logic [ROW_W-1:0] row_c;

  always_comb begin
    col_c = (point_col_r > cols_eff) ? cols_eff : point_col_r;
    row_c = (point_row_r > rows_eff) ? rows_eff : point_row_r;
    point_col_nxt = point_col_r;
    point_row_nxt = point_row_r;
    if (in_xfer) begin
      if (col_c >= cols_eff) begin
        point_col_nxt = '0;
        point_row_nxt = (row_c >= rows_eff) ? '0 : row_c + ROW_W'(1);
      end else begin
        point_col_nxt = col_c + LB_AW'(1);
        point_row_nxt = row_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      point_col_r <= '0;
      point_row_r <= '0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      out_v_r     <= out_v_nxt;
      point_col_r <= point_col_nxt;
      point_row_r <= point_row_nxt;
    end
  end

  // stage 1: line buffer access
  point_t cur_pt;
  point_t north_pt;
  point_t s1_cur_r;
  logic [COORD_W-1:0] s1_col_r;
  logic [COORD_W-1:0] s1_row_r;
  logic               s1_last_r;
  logic [CMP_W-1:0]   col_m1;
  logic [ROW_W-1:0]   row_m1;

  assign cur_pt = point_t'(in_tdata[$bits(point_t)-1:0]);
  assign col_m1 = CMP_W'(col_c) - CMP_W'(1);
  assign row_m1 = row_c - ROW_W'(1);

  gchsc_line_buf u_line_buf (
    .clk     (clk),
    .en      (in_xfer),
    .addr    (col_c),
    .wr_data (cur_pt),
    .rd_data (north_pt)
  );

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cur_r  <= cur_pt;
      s1_emit_r <= (col_c != '0) && (row_c != '0);
      s1_col_r  <= col_m1[COORD_W-1:0];
      s1_row_r  <= row_m1[COORD_W-1:0];
      s1_last_r <= (col_c == cols_eff) && (row_c == rows_eff);
    end
  end

  // west corners
  point_t west_w_r;
  point_t west_nw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      west_w_r  <= '0;
      west_nw_r <= '0;
    end else if (s1_go) begin
      west_w_r  <= s1_cur_r;
      west_nw_r <= north_pt;
    end
  end

  // stage 2: corner statistics
  layer_stat_t t_stat, b_stat;
  layer_stat_t t_stat_r, b_stat_r;
  logic [COORD_W-1:0] s2_col_r;
  logic [COORD_W-1:0] s2_row_r;
  logic               s2_last_r;

  gchsc_layer_reduce u_terrain_reduce (
    .h_nw (west_nw_r.terrain_height),
    .h_ne (north_pt.terrain_height),
    .h_sw (west_w_r.terrain_height),
    .h_se (s1_cur_r.terrain_height),
    .i_nw (west_nw_r.terrain_inf),
    .i_ne (north_pt.terrain_inf),
    .i_sw (west_w_r.terrain_inf),
    .i_se (s1_cur_r.terrain_inf),
    .stat (t_stat)
  );

  gchsc_layer_reduce u_bridge_reduce (
    .h_nw (west_nw_r.bridge_height),
    .h_ne (north_pt.bridge_height),
    .h_sw (west_w_r.bridge_height),
    .h_se (s1_cur_r.bridge_height),
    .i_nw (west_nw_r.bridge_inf),
    .i_ne (north_pt.bridge_inf),
    .i_sw (west_w_r.bridge_inf),
    .i_se (s1_cur_r.bridge_inf),
    .stat (b_stat)
  );

  always_ff @(posedge clk) begin
    if (s1_go && s1_emit_r) begin
      t_stat_r  <= t_stat;
      b_stat_r  <= b_stat;
      s2_col_r  <= s1_col_r;
      s2_row_r  <= s1_row_r;
      s2_last_r <= s1_last_r;
    end
  end

  // stage 3: cell results into the output register
  height_t t_height, b_height;
  logic    t_inf, b_inf, t_blocked, b_blocked;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_last_r;

  gchsc_layer_eval u_terrain_eval (
    .stat        (t_stat_r),
    .slope_limit (slope_limit_r),
    .cell_height (t_height),
    .cell_inf    (t_inf),
    .blocked     (t_blocked)
  );

  gchsc_layer_eval u_bridge_eval (
    .stat        (b_stat_r),
    .slope_limit (slope_limit_r),
    .cell_height (b_height),
    .cell_inf    (b_inf),
    .blocked     (b_blocked)
  );

  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_data_r <= {s2_row_r, s2_col_r, b_blocked, b_inf, b_height,
                     t_blocked, t_inf, t_height};
      out_last_r <= s2_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  a_point_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (point_col_r <= LB_AW'(MAX_CELL_COLS)) && (point_row_r <= ROW_W'(ROW_LIMIT)))
    else $error("point position beyond map limits");

  a_xfer_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> s1_v_r)
    else $error("accepted point missing from line buffer stage");

  a_terrain_inf_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[24]) |-> (out_tdata[25] && (out_tdata[23:0] == '0)))
    else $error("infinite terrain cell not blocked or height not zero");

  a_bridge_inf_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[50]) |-> (out_tdata[51] && (out_tdata[49:26] == '0)))
    else $error("infinite bridge cell not blocked or height not zero");
`endif

endmodule

// ----- design/gchsc_line_buf.sv -----
// ----------------------------------------------------------------------------
// gchsc_line_buf: previous point row store
// One address shared by read and write, read data registered, old data on collision.
// ----------------------------------------------------------------------------
module gchsc_line_buf import gchsc_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [LB_AW-1:0] addr,
  input  point_t           wr_data,
  output point_t           rd_data
);

  point_t mem [LB_DEPTH];
  point_t rd_data_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rd_data_r  <= mem[addr];
      mem[addr]  <= wr_data;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/gchsc_layer_reduce.sv -----
// ----------------------------------------------------------------------------
// gchsc_layer_reduce: corner statistics of one layer
// Minimum, maximum and infinity over the four corners of a window.
// ----------------------------------------------------------------------------
module gchsc_layer_reduce import gchsc_pkg::*; (
  input  height_t     h_nw,
  input  height_t     h_ne,
  input  height_t     h_sw,
  input  height_t     h_se,
  input  logic        i_nw,
  input  logic        i_ne,
  input  logic        i_sw,
  input  logic        i_se,
  output layer_stat_t stat
);

  height_t mn_n;
  height_t mn_s;
  height_t mx_n;
  height_t mx_s;

  always_comb begin
    mn_n = (h_ne < h_nw) ? h_ne : h_nw;
    mx_n = (h_ne > h_nw) ? h_ne : h_nw;
    mn_s = (h_se < h_sw) ? h_se : h_sw;
    mx_s = (h_se > h_sw) ? h_se : h_sw;
    stat.mn  = (mn_s < mn_n) ? mn_s : mn_n;
    stat.mx  = (mx_s > mx_n) ? mx_s : mx_n;
    stat.inf = i_nw | i_ne | i_sw | i_se;
  end

endmodule

// ----- design/gchsc_layer_eval.sv -----
// ----------------------------------------------------------------------------
// gchsc_layer_eval: cell height and blocked flag of one layer
// Floored midpoint of min and max, range against the threshold.
// ----------------------------------------------------------------------------
module gchsc_layer_eval import gchsc_pkg::*; (
  input  layer_stat_t        stat,
  input  logic [DELTA_W-1:0] slope_limit,
  output height_t            cell_height,
  output logic               cell_inf,
  output logic               blocked
);

  logic signed [HEIGHT_BITS:0] sum;
  logic signed [HEIGHT_BITS:0] span;

  always_comb begin
    sum  = $signed({stat.mn[HEIGHT_BITS-1], stat.mn})
         + $signed({stat.mx[HEIGHT_BITS-1], stat.mx});
    span = $signed({stat.mx[HEIGHT_BITS-1], stat.mx})
         - $signed({stat.mn[HEIGHT_BITS-1], stat.mn});
    cell_inf = stat.inf;
    if (stat.inf) begin
      cell_height = '0;
      blocked     = 1'b1;
    end else begin
      // arithmetic halving floors toward minus infinity
      cell_height = sum[HEIGHT_BITS:1];
      blocked     = ($unsigned(span) >= (HEIGHT_BITS+1)'(slope_limit));
    end
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for grid_cell_height_slope_classifier_unit
// Streams raster height maps through the block and predicts every cell from
// its own copy of the line buffer, corner window and counters. Directed maps
// cover threshold edges, infinite corners, count clamping and count changes
// mid-map; random maps follow under varying source idling and sink stalls.
// ----------------------------------------------------------------------------
module tb import gchsc_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int          SETTLE_CYCLES = 10;

  typedef struct packed {
    logic    blocked;
    logic    inf;
    height_t height;
  } layer_cell_t;

  typedef struct packed {
    logic               last;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    layer_cell_t        bridge;
    layer_cell_t        terrain;
  } cell_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // terrain_height, terrain_inf, bridge_height, bridge_inf, zero fill
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // terrain_cell_height, terrain_cell_inf, terrain_blocked,
  // bridge_cell_height, bridge_cell_inf, bridge_blocked, cell_col, cell_row
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  grid_cell_height_slope_classifier_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted block state
  point_t                 line_buf [0:LB_DEPTH-1];
  point_t                 west_pt, nw_pt;
  int unsigned            next_col, next_row;
  logic [DELTA_W-1:0]     delta_r;
  logic [CFG_COUNT_W-1:0] cols_r, rows_r;
  cell_t                  expected_cells [$];

  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          mismatches = 0;
  int          points_sent = 0;
  int unsigned cycle_count = 0;

  // height style of the current map
  height_t     hbase;
  int unsigned hspread;
  int          inf_pct, wide_pct;

  function automatic layer_cell_t layer_cell(input point_t c0, c1, c2, c3,
                                             input bit bridge_layer);
    point_t                      corner [4];
    height_t                     h, lo, hi;
    logic signed [HEIGHT_BITS:0] lo_x, hi_x, sum;
    logic [HEIGHT_BITS:0]        span;
    layer_cell_t                 r;
    int                          k;
    corner[0] = c0;
    corner[1] = c1;
    corner[2] = c2;
    corner[3] = c3;
    r = '0;
    lo = bridge_layer ? c0.bridge_height : c0.terrain_height;
    hi = lo;
    for (k = 0; k < 4; k++) begin
      h = bridge_layer ? corner[k].bridge_height : corner[k].terrain_height;
      if (h < lo) lo = h;
      if (h > hi) hi = h;
      if (bridge_layer ? corner[k].bridge_inf : corner[k].terrain_inf) r.inf = 1'b1;
    end
    if (r.inf) begin
      r.blocked = 1'b1;
    end else begin
      lo_x = (HEIGHT_BITS+1)'(lo);
      hi_x = (HEIGHT_BITS+1)'(hi);
      sum = lo_x + hi_x;
      r.height = height_t'(sum >>> 1);
      span = hi_x - lo_x;
      r.blocked = (span >= delta_r);
    end
    return r;
  endfunction

  function automatic void advance_raster(input point_t p);
    int unsigned cols, rows, c, r;
    point_t      north;
    cell_t       exp_cell;
    cols = 32'(cols_r);
    rows = 32'(rows_r);
    if (cols < 1) cols = 1;
    if (cols > MAX_CELL_COLS) cols = MAX_CELL_COLS;
    if (rows < 1) rows = 1;
    if (rows > ROW_LIMIT) rows = ROW_LIMIT;
    c = (next_col > cols) ? cols : next_col;
    r = (next_row > rows) ? rows : next_row;
    north = line_buf[LB_AW'(c)];
    if (c > 0 && r > 0) begin
      exp_cell.terrain = layer_cell(nw_pt, north, west_pt, p, 1'b0);
      exp_cell.bridge  = layer_cell(nw_pt, north, west_pt, p, 1'b1);
      exp_cell.col     = COORD_W'(c - 1);
      exp_cell.row     = COORD_W'(r - 1);
      exp_cell.last    = (c == cols && r == rows);
      expected_cells.push_back(exp_cell);
    end
    nw_pt = north;
    west_pt = p;
    line_buf[LB_AW'(c)] = p;
    if (c >= cols) begin
      c = 0;
      if (r >= rows) r = 0;
      else r++;
    end else begin
      c++;
    end
    next_col = c;
    next_row = r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input cell_t want,
                             input logic [HEIGHT_BITS-1:0] got_v, exp_v);
    if (got_v !== exp_v)
      report_mismatch($sformatf("cell (%0d,%0d) %s got %h want %h",
                                want.col, want.row, name, got_v, exp_v));
  endtask

  task automatic check_cell(input cell_t got);
    cell_t want;
    if (expected_cells.size() == 0) begin
      report_mismatch($sformatf("unexpected cell %h", got));
      return;
    end
    want = expected_cells.pop_front();
    check_field("terrain height", want, got.terrain.height, want.terrain.height);
    check_field("terrain inf", want, HEIGHT_BITS'(got.terrain.inf),
                HEIGHT_BITS'(want.terrain.inf));
    check_field("terrain blocked", want, HEIGHT_BITS'(got.terrain.blocked),
                HEIGHT_BITS'(want.terrain.blocked));
    check_field("bridge height", want, got.bridge.height, want.bridge.height);
    check_field("bridge inf", want, HEIGHT_BITS'(got.bridge.inf),
                HEIGHT_BITS'(want.bridge.inf));
    check_field("bridge blocked", want, HEIGHT_BITS'(got.bridge.blocked),
                HEIGHT_BITS'(want.bridge.blocked));
    check_field("col", want, HEIGHT_BITS'(got.col), HEIGHT_BITS'(want.col));
    check_field("row", want, HEIGHT_BITS'(got.row), HEIGHT_BITS'(want.row));
    check_field("last", want, HEIGHT_BITS'(got.last), HEIGHT_BITS'(want.last));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_cell(cell_t'({out_tlast, out_tdata}));
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_point(input point_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W - $bits(point_t)){1'b0}}, p};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    advance_raster(p);
    points_sent++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SLOPE_LIMIT: delta_r = val[DELTA_W-1:0];
      REG_CELL_COLS:   cols_r = val[CFG_COUNT_W-1:0];
      REG_CELL_ROWS:   rows_r = val[CFG_COUNT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic point_t pt(input int th, input bit ti, input int bh, input bit bi);
    point_t p;
    p.terrain_height = height_t'(th);
    p.terrain_inf    = ti;
    p.bridge_height  = height_t'(bh);
    p.bridge_inf     = bi;
    return p;
  endfunction

  function automatic void pick_heights();
    hbase = height_t'($urandom);
    if ($urandom_range(3) == 0 || delta_r > 24'h100000) hspread = $urandom_range(0, 1 << 23);
    else hspread = $urandom_range(0, 2 * delta_r + 8);
    case ($urandom_range(3))
      0:       inf_pct = 0;
      1:       inf_pct = 20;
      default: inf_pct = 3;
    endcase
    wide_pct = ($urandom_range(4) == 0) ? 30 : 0;
  endfunction

  function automatic height_t rand_height();
    if ($urandom_range(99) < wide_pct) return height_t'($urandom);
    return hbase + height_t'($urandom_range(0, hspread)) - height_t'(hspread / 2);
  endfunction

  function automatic point_t rand_point();
    point_t p;
    p.terrain_height = rand_height();
    p.terrain_inf    = ($urandom_range(99) < inf_pct);
    p.bridge_height  = rand_height();
    p.bridge_inf     = ($urandom_range(99) < inf_pct);
    return p;
  endfunction

  // runs on to the end of the current map
  task automatic fill_map();
    do send_point(rand_point());
    while (!(next_col == 0 && next_row == 0));
  endtask

  task automatic send_window(input point_t nw, ne, sw, se);
    send_point(nw);
    send_point(ne);
    send_point(sw);
    send_point(se);
    settle();
  endtask

  // part of a row at reset settings, then the row and the map cut short
  task automatic test_reset_defaults();
    pick_heights();
    repeat (48) send_point(rand_point());
    settle();
    write_reg(REG_CELL_COLS, 12);
    write_reg(REG_CELL_ROWS, 1);
    fill_map();
  endtask

  task automatic test_corner_windows();
    settle();
    write_reg(REG_CELL_COLS, 1);
    write_reg(REG_CELL_ROWS, 1);
    write_reg(REG_SLOPE_LIMIT, 0);
    send_window(pt(0, 0, 0, 0), pt(0, 0, 0, 0), pt(0, 0, 0, 0), pt(0, 0, 0, 0));
    write_reg(REG_SLOPE_LIMIT, 24'hFFFFFF);
    send_window(pt(-8388608, 0, -8388608, 0), pt(8388607, 0, 8388606, 0),
                pt(0, 0, 1, 0), pt(100, 0, -1, 0));
    write_reg(REG_SLOPE_LIMIT, 5);
    send_window(pt(-3, 0, 10, 0), pt(0, 0, 15, 0), pt(-1, 0, 12, 0), pt(-2, 0, 11, 0));
    // zero counts behave as one
    write_reg(REG_CELL_COLS, 0);
    write_reg(REG_CELL_ROWS, 0);
    send_window(pt(7777, 1, 50, 0), pt(7777, 0, 51, 0), pt(7777, 0, 52, 0),
                pt(7777, 0, 53, 1));
    send_window(pt(-20, 0, 300, 0), pt(-20, 1, 300, 0), pt(-20, 0, 300, 1),
                pt(-20, 0, 300, 0));
    send_window(pt(8388607, 0, -8388608, 0), pt(8388607, 0, -8388608, 0),
                pt(8388607, 0, -8388608, 0), pt(8388607, 0, -8388608, 0));
  endtask

  // oversized counts, each later cut down mid-map
  task automatic test_count_clamp();
    write_reg(REG_SLOPE_LIMIT, 256);
    write_reg(REG_CELL_COLS, 2047);
    write_reg(REG_CELL_ROWS, 2047);
    pick_heights();
    repeat (15) send_point(rand_point());
    settle();
    write_reg(REG_CELL_COLS, 4);
    write_reg(REG_CELL_ROWS, 1);
    fill_map();
    settle();
    write_reg(REG_CELL_COLS, 1);
    write_reg(REG_CELL_ROWS, 2047);
    repeat (6) send_point(rand_point());
    settle();
    write_reg(REG_CELL_ROWS, 2);
    fill_map();
    settle();
  endtask

  task automatic test_midmap_counts();
    write_reg(REG_CELL_COLS, 6);
    write_reg(REG_CELL_ROWS, 4);
    write_reg(REG_SLOPE_LIMIT, 40);
    pick_heights();
    repeat (10) send_point(rand_point());
    settle();
    write_reg(REG_CELL_COLS, 2);
    repeat (4) send_point(rand_point());
    settle();
    write_reg(REG_CELL_ROWS, 1);
    fill_map();
    repeat (5) send_point(rand_point());
    settle();
    write_reg(REG_CELL_COLS, 9);
    fill_map();
    settle();
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_delta();
    case ($urandom_range(5))
      0:       return '0;
      1:       return 24'hFFFFFF;
      2, 3:    return CFG_DATA_W'($urandom_range(0, 600));
      4:       return CFG_DATA_W'($urandom_range(0, 1 << 16));
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_cols();
    case ($urandom_range(9))
      0:       return '0;
      1:       return CFG_DATA_W'($urandom_range(9, 40));
      default: return CFG_DATA_W'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_rows();
    if ($urandom_range(9) == 0) return '0;
    return CFG_DATA_W'($urandom_range(1, 5));
  endfunction

  task automatic test_random_maps(input int n_points);
    int target;
    target = points_sent + n_points;
    while (points_sent < target) begin
      if ($urandom_range(1) == 0) begin
        settle();
        if ($urandom_range(1)) write_reg(REG_SLOPE_LIMIT, rand_delta());
        if ($urandom_range(1)) write_reg(REG_CELL_COLS, rand_cols());
        if ($urandom_range(1)) write_reg(REG_CELL_ROWS, rand_rows());
      end
      pick_heights();
      if ($urandom_range(5) == 0) begin
        repeat ($urandom_range(1, 12)) send_point(rand_point());
        settle();
        if ($urandom_range(1)) write_reg(REG_CELL_COLS, rand_cols());
        else write_reg(REG_CELL_ROWS, rand_rows());
      end
      fill_map();
    end
  endtask

  initial begin
    line_buf = '{default: '0};
    west_pt = '0;
    nw_pt = '0;
    next_col = 0;
    next_row = 0;
    delta_r = DELTA_RESET;
    cols_r = COLS_RESET;
    rows_r = ROWS_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_corner_windows();
    test_count_clamp();
    test_midmap_counts();

    send_idle_pct = 0;
    stall_pct = 0;
    test_random_maps(140);
    send_idle_pct = 87;
    test_random_maps(140);
    send_idle_pct = 0;
    stall_pct = 87;
    test_random_maps(140);
    send_idle_pct = 22;
    stall_pct = 22;
    test_random_maps(140);

    settle();
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
